FILE: rtl/core/rras_pkg.sv
// Shared constants and types for the converter statistics block.
package rras_pkg;
   localparam int SampleBits    = 12;
   localparam int CountBitsDef  = 20;
   localparam int SumBits       = 32;
   localparam int TallyBits     = 16;
   localparam int LoadBits      = 15;
   localparam int TempBits      = 19;
   localparam int MinBits       = SampleBits + 1;
   localparam int MaxBits       = SampleBits;
   localparam int AvgBits       = SampleBits;
   localparam int ChBits        = 2;
   localparam int QueueDepth    = 2;

   localparam logic [ChBits-1:0] ChIdle0 = 2'd0;
   localparam logic [ChBits-1:0] ChIdle1 = 2'd1;
   localparam logic [ChBits-1:0] ChTemp  = 2'd2;

   localparam logic OpSample = 1'b0;
   localparam logic OpRead   = 1'b1;

   typedef struct packed {
      logic                  op;
      logic [SampleBits-1:0] sample;
      logic                  sample_error;
      logic [ChBits-1:0]     channel;
   } cmd_type;
endpackage

FILE: rtl/core/rras_front.sv
// Front end: accept items, tag samples with the round-robin channel, drop bad reads.
module rras_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  logic                            req_op,
   input  logic [rras_pkg::SampleBits-1:0] req_sample,
   input  logic                            req_sample_error,
   input  logic [rras_pkg::ChBits-1:0]     req_read_channel,
   output logic                            q_valid,
   output rras_pkg::cmd_type               q_cmd,
   input  logic                            q_take
);
   import rras_pkg::*;
   logic [ChBits-1:0] active_ff, active_in;
   cmd_type           mem_ff [QueueDepth];
   logic              wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              acc, keep;
   cmd_type           cmd;

   assign req_full = (cnt_ff == 2'(QueueDepth));
   assign acc      = req_push && !req_full;
   assign keep     = acc && (req_op == OpSample || req_read_channel <= ChTemp);

   always_comb begin
      cmd              = '0;
      cmd.op           = req_op;
      cmd.sample       = req_sample;
      cmd.sample_error = req_sample_error;
      cmd.channel      = (req_op == OpSample) ? active_ff : req_read_channel;
      active_in        = active_ff;
      if (acc && req_op == OpSample) begin
         active_in = (active_ff == ChTemp) ? ChIdle0 : active_ff + 2'd1;
      end
   end

   assign q_valid = cnt_ff != 2'd0;
   assign q_cmd   = mem_ff[rp_ff];
   assign wp_in   = keep ? ~wp_ff : wp_ff;
   assign rp_in   = (q_take && q_valid) ? ~rp_ff : rp_ff;
   assign cnt_in  = cnt_ff + {1'b0, keep} - {1'b0, q_take && q_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ChTemp;
         wp_ff     <= 1'b0;
         rp_ff     <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         active_ff <= active_in;
         wp_ff     <= wp_in;
         rp_ff     <= rp_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (keep) begin
         mem_ff[wp_ff] <= cmd;
      end
   end
endmodule

FILE: rtl/core/rras_back.sv
// Back end: update channel statistics, divide and scale on reads, hold the result.
module rras_back #(
   parameter int COUNT_BITS  = rras_pkg::CountBitsDef
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  q_valid,
   input  rras_pkg::cmd_type                     q_cmd,
   output logic                                  q_take,
   output logic                                  rsp_empty,
   input  logic                                  rsp_pop,
   output logic [rras_pkg::ChBits-1:0]           rsp_channel_read,
   output logic [COUNT_BITS-1:0]                 rsp_sample_count,
   output logic [rras_pkg::SumBits-1:0]          rsp_sample_sum,
   output logic [rras_pkg::MinBits-1:0]          rsp_min_raw,
   output logic [rras_pkg::MaxBits-1:0]          rsp_max_raw,
   output logic [rras_pkg::AvgBits-1:0]          rsp_average_raw,
   output logic [rras_pkg::LoadBits-1:0]         rsp_min_load,
   output logic [rras_pkg::LoadBits-1:0]         rsp_avg_load,
   output logic [rras_pkg::LoadBits-1:0]         rsp_max_load,
   output logic signed [rras_pkg::TempBits-1:0]  rsp_temperature_centi,
   output logic [rras_pkg::TallyBits-1:0]        rsp_error_count,
   output logic                                  rsp_average_valid
);
   import rras_pkg::*;
   localparam int SB = SampleBits;
   localparam logic [SB:0] FullScale = (SB+1)'(1) << SB;
   localparam logic [SB-1:0] SampleMax = '1;
   localparam logic [COUNT_BITS-1:0] CountMax = '1;

   // temperature numerator and divisor scaled down by 128
   localparam logic [21:0] TMul   = 22'd2578125;
   localparam logic [33:0] TOff   = 34'd2259200000;
   localparam logic [33:0] THalf  = 34'd27536;
   // reciprocal of 1721, exact for numerators below 2**28
   localparam logic [28:0] TRecip = 29'd319439753;
   localparam logic signed [TempBits-1:0] TBase = TempBits'(2700);

   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StDiv  = 3'd1;
   localparam logic [2:0] StMul  = 3'd2;
   localparam logic [2:0] StTmul = 3'd3;
   localparam logic [2:0] StTsub = 3'd4;
   localparam logic [2:0] StTrec = 3'd5;
   localparam logic [2:0] StOut  = 3'd6;

   logic [COUNT_BITS-1:0] cnt_ff [3];
   logic [SumBits-1:0]    sum_ff [3];
   logic [SB:0]           mn_ff  [2];
   logic [SB-1:0]         mx_ff  [2];
   logic [TallyBits-1:0]  tally_ff;

   logic [2:0]            st_ff;
   logic [4:0]            step_ff;
   logic [ChBits-1:0]     ch_ff;
   logic [COUNT_BITS-1:0] rcnt_ff;
   logic [SumBits-1:0]    rsum_ff, dvd_ff, quo_ff;
   logic [COUNT_BITS:0]   rem_ff;
   logic [SB:0]           rmn_ff;
   logic [SB-1:0]         rmx_ff;
   logic [SB-1:0]         avg_ff;
   logic [33:0]           tprod_ff;
   logic                  tneg_ff;
   logic [27:0]           tnum_ff;
   logic [17:0]           tq_ff;
   logic                  full_ff, full_in;

   logic [ChBits-1:0]     o_ch_ff;
   logic [COUNT_BITS-1:0] o_cnt_ff;
   logic [SumBits-1:0]    o_sum_ff;
   logic [SB:0]           o_mn_ff;
   logic [SB-1:0]         o_mx_ff, o_avg_ff;
   logic [LoadBits-1:0]   o_lmin_ff, o_lavg_ff, o_lmax_ff;
   logic signed [TempBits-1:0] o_temp_ff;
   logic [TallyBits-1:0]  o_tally_ff;
   logic                  o_valid_ff;

   function automatic logic [LoadBits-1:0] load_q88(input logic [SB:0] x);
      logic [SB:0]  d;
      logic [SB+15:0] p;
      d = FullScale - ((x > FullScale) ? FullScale : x);
      p = (SB+16)'(d) * (SB+16)'(25600) + (SB+16)'(FullScale >> 1);
      return LoadBits'(p >> SB);
   endfunction

   logic              is_idle;
   logic [COUNT_BITS:0] rem_sh;
   logic [33:0]       tdiff;
   logic [56:0]       tmul;
   logic [ChBits-1:0] c;
   logic [SB-1:0]     sv;
   logic [SumBits:0]  nsum;
   logic              valid;
   logic              out_load;

   assign q_take   = (st_ff == StIdle) && q_valid &&
                     (q_cmd.op == OpSample || !full_ff);
   assign c        = q_cmd.channel;
   assign sv       = q_cmd.sample;
   assign nsum     = {1'b0, sum_ff[c]} + (SumBits+1)'(sv);
   assign valid    = rcnt_ff != '0;
   assign is_idle  = ch_ff != ChTemp;
   assign rem_sh   = {rem_ff[COUNT_BITS-1:0], dvd_ff[SumBits-1]};
   assign tdiff    = (tprod_ff < TOff) ? TOff - tprod_ff : tprod_ff - TOff;
   assign tmul     = 57'(tnum_ff) * 57'(TRecip);
   assign out_load = (st_ff == StOut) && (!full_ff || rsp_pop);
   assign full_in  = out_load || (full_ff && !rsp_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            cnt_ff[i] <= '0;
            sum_ff[i] <= '0;
         end
         for (int i = 0; i < 2; i++) begin
            mn_ff[i] <= FullScale;
            mx_ff[i] <= '0;
         end
         tally_ff <= '0;
         st_ff    <= StIdle;
         full_ff  <= 1'b0;
      end else begin
         full_ff <= full_in;
         case (st_ff)
            StIdle: begin
               if (q_take && q_cmd.op == OpSample) begin
                  if (q_cmd.sample_error) begin
                     if (tally_ff != '1) tally_ff <= tally_ff + 1'b1;
                  end else begin
                     if (cnt_ff[c] != CountMax) cnt_ff[c] <= cnt_ff[c] + 1'b1;
                     sum_ff[c] <= nsum[SumBits] ? '1 : nsum[SumBits-1:0];
                     if (c != ChTemp) begin
                        if ({1'b0, sv} < mn_ff[c[0]]) mn_ff[c[0]] <= {1'b0, sv};
                        if (sv > mx_ff[c[0]]) mx_ff[c[0]] <= sv;
                     end
                  end
               end else if (q_take) begin
                  ch_ff   <= c;
                  rcnt_ff <= cnt_ff[c];
                  rsum_ff <= sum_ff[c];
                  dvd_ff  <= sum_ff[c];
                  rmn_ff  <= (c == ChTemp) ? FullScale : mn_ff[c[0]];
                  rmx_ff  <= (c == ChTemp) ? '0 : mx_ff[c[0]];
                  cnt_ff[c] <= '0;
                  sum_ff[c] <= '0;
                  if (c != ChTemp) begin
                     mn_ff[c[0]] <= FullScale;
                     mx_ff[c[0]] <= '0;
                  end
                  rem_ff  <= '0;
                  quo_ff  <= '0;
                  step_ff <= '0;
                  st_ff   <= StDiv;
               end
            end
            StDiv: begin
               if (rem_sh >= {1'b0, rcnt_ff} && valid) begin
                  rem_ff <= rem_sh - {1'b0, rcnt_ff};
                  quo_ff <= {quo_ff[SumBits-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_sh;
                  quo_ff <= {quo_ff[SumBits-2:0], 1'b0};
               end
               dvd_ff  <= {dvd_ff[SumBits-2:0], 1'b0};
               step_ff <= step_ff + 1'b1;
               if (step_ff == 5'(SumBits - 1)) st_ff <= StMul;
            end
            StMul: begin
               if (!valid) avg_ff <= '0;
               else if (quo_ff > SumBits'(SampleMax)) avg_ff <= SampleMax;
               else avg_ff <= quo_ff[SB-1:0];
               st_ff <= StTmul;
            end
            StTmul: begin
               tprod_ff <= 34'(avg_ff) * 34'(TMul);
               st_ff    <= StTsub;
            end
            StTsub: begin
               tneg_ff <= tprod_ff < TOff;
               tnum_ff <= 28'((tdiff + THalf) >> 5);
               st_ff   <= StTrec;
            end
            StTrec: begin
               tq_ff <= tmul[56:39];
               st_ff <= StOut;
            end
            StOut: begin
               if (out_load) st_ff <= StIdle;
            end
            default: st_ff <= StIdle;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         o_ch_ff    <= ch_ff;
         o_cnt_ff   <= rcnt_ff;
         o_sum_ff   <= rsum_ff;
         o_mn_ff    <= rmn_ff;
         o_mx_ff    <= rmx_ff;
         o_avg_ff   <= avg_ff;
         o_lmin_ff  <= is_idle ? load_q88({1'b0, rmx_ff}) : '0;
         o_lmax_ff  <= is_idle ? load_q88(rmn_ff) : '0;
         o_lavg_ff  <= (is_idle && valid) ? load_q88({1'b0, avg_ff}) : '0;
         o_temp_ff  <= (!is_idle && valid) ?
                       (tneg_ff ? TBase + $signed({1'b0, tq_ff})
                                : TBase - $signed({1'b0, tq_ff}))
                       : '0;
         o_tally_ff <= tally_ff;
         o_valid_ff <= valid;
      end
   end

   assign rsp_empty             = !full_ff;
   assign rsp_channel_read      = o_ch_ff;
   assign rsp_sample_count      = o_cnt_ff;
   assign rsp_sample_sum        = o_sum_ff;
   assign rsp_min_raw           = o_mn_ff;
   assign rsp_max_raw           = o_mx_ff;
   assign rsp_average_raw       = o_avg_ff;
   assign rsp_min_load          = o_lmin_ff;
   assign rsp_avg_load          = o_lavg_ff;
   assign rsp_max_load          = o_lmax_ff;
   assign rsp_temperature_centi = o_temp_ff;
   assign rsp_error_count       = o_tally_ff;
   assign rsp_average_valid     = o_valid_ff;
endmodule

FILE: rtl/core/round_robin_adc_statistics.sv
// Top level of the round-robin converter statistics block.
// Input queue: req_push with req_full; op 0 is a sample for the current
// round-robin channel (temperature, idle 0, idle 1, starting on temperature),
// op 1 reads and clears channel req_read_channel (channel 3 is dropped).
// Result queue: rsp_empty low shows the oldest result; rsp_pop takes it.
// Samples produce no result; the back end retires one per cycle when idle.
// When the back end is idle, a read's result appears after the queue, the 32
// steps of the sum/count restoring divider, the clamp state, the temperature
// scaling states (multiply, subtract, reciprocal) and the output state.
// The back end takes no new item until a read's result is in the result register.
// A two-entry queue sits between the front and back ends, so pushes keep
// landing while a read is being divided.
// Reset clears all statistics, the error tally and the queues, and sets the
// round robin to the temperature channel.
// While a result waits unpopped, the next read stalls in front of the back
// end; items behind it wait in the queue and req_full rises when it fills.
module round_robin_adc_statistics #(
   parameter int COUNT_BITS  = rras_pkg::CountBitsDef
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   output logic                           req_full,
   input  logic                           req_op,
   input  logic [rras_pkg::SampleBits-1:0] req_sample,
   input  logic                           req_sample_error,
   input  logic [rras_pkg::ChBits-1:0]    req_read_channel,
   output logic                           rsp_empty,
   input  logic                           rsp_pop,
   output logic [rras_pkg::ChBits-1:0]    rsp_channel_read,
   output logic [COUNT_BITS-1:0]          rsp_sample_count,
   output logic [rras_pkg::SumBits-1:0]   rsp_sample_sum,
   output logic [rras_pkg::MinBits-1:0]   rsp_min_raw,
   output logic [rras_pkg::MaxBits-1:0]   rsp_max_raw,
   output logic [rras_pkg::AvgBits-1:0]   rsp_average_raw,
   output logic [rras_pkg::LoadBits-1:0]  rsp_min_load,
   output logic [rras_pkg::LoadBits-1:0]  rsp_avg_load,
   output logic [rras_pkg::LoadBits-1:0]  rsp_max_load,
   output logic signed [rras_pkg::TempBits-1:0] rsp_temperature_centi,
   output logic [rras_pkg::TallyBits-1:0] rsp_error_count,
   output logic                           rsp_average_valid
);
   import rras_pkg::*;
   logic    q_valid, q_take;
   cmd_type q_cmd;

   rras_front u_front (
      .clock, .reset, .req_push, .req_full, .req_op, .req_sample,
      .req_sample_error, .req_read_channel, .q_valid, .q_cmd, .q_take
   );

   rras_back #(.COUNT_BITS(COUNT_BITS)) u_back (
      .clock, .reset, .q_valid, .q_cmd, .q_take, .rsp_empty, .rsp_pop,
      .rsp_channel_read, .rsp_sample_count, .rsp_sample_sum, .rsp_min_raw,
      .rsp_max_raw, .rsp_average_raw, .rsp_min_load, .rsp_avg_load,
      .rsp_max_load, .rsp_temperature_centi, .rsp_error_count,
      .rsp_average_valid
   );
endmodule
